FILE: src/sra_pkg.sv
// Shared definitions for the step response analyser: widths, register indexes,
// status codes, reset values and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package sra_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int TIME_BITS_DEF     = 32;

  localparam int FRAC_W     = 16;
  localparam int THRESH_W   = 31;
  localparam int COUNT_W    = 16;
  localparam int OVS_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DIV_STEPS = OVS_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [FRAC_W-1:0] OVS_SCALE = FRAC_W'(10000);
  localparam logic [OVS_W-1:0]  OVS_MAX   = OVS_W'(32767);

  localparam logic [THRESH_W-1:0] RST_STEP_THRESHOLD = THRESH_W'(6554);
  localparam logic [FRAC_W-1:0]   RST_RISE_LOW       = FRAC_W'(6554);
  localparam logic [FRAC_W-1:0]   RST_RISE_HIGH      = FRAC_W'(58982);
  localparam logic [FRAC_W-1:0]   RST_SETTLE_BAND    = FRAC_W'(1311);
  localparam logic [COUNT_W-1:0]  RST_MIN_SAMPLES    = COUNT_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_THRESHOLD       = 3'd0,
    CFG_RISE_LOW_FRACTION    = 3'd1,
    CFG_RISE_HIGH_FRACTION   = 3'd2,
    CFG_SETTLE_BAND_FRACTION = 3'd3,
    CFG_MIN_SAMPLES          = 3'd4
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_TOO_FEW = 2'd1,
    STATUS_NO_STEP = 2'd2
  } status_t;

  typedef struct packed {
    logic load_sample;
    logic detect;
    logic mul_lo;
    logic mul_hi;
    logic mul_band;
    logic band_done;
    logic track;
    logic ovs_diff;
    logic ovs_mul;
    logic div_init;
    logic div_step;
    logic finish;
  } sra_cmd_t;

  typedef struct packed {
    logic step_hit;
    logic last;
  } sra_sts_t;

endpackage

FILE: src/step_response_analyzer.sv
// Top level of the step response analyser: joins the controller and the datapath.
// Uses sra_pkg, sra_ctrl and sra_datapath.
`timescale 1ns / 1ps

// Analyses one record of desired/actual position samples for a step response.
// One sample is taken at a time: an ordinary sample occupies the block for
// capture, step test and tracking update; the sample that holds the step also
// for the rise levels and the settling band (these come from one shared
// (POSITION_BITS+1) x 16 multiplier, one product per cycle), and the sample
// marked last further for the overshoot, which the restoring divider forms one
// quotient bit per cycle. The result waits in an output register while the
// next record's samples are taken; a last sample whose result finds that
// register still occupied waits for it. Configuration writes are accepted in
// every cycle and are meant for idle time.
module step_response_analyzer import sra_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [POSITION_BITS-1:0] in_desired_position,
  input  logic signed [POSITION_BITS-1:0] in_actual_position,
  input  logic [TIME_BITS-1:0]            in_sample_time,
  input  logic                            in_last_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [STATUS_W-1:0]             out_status,
  output logic signed [TIME_BITS:0]       out_rise_time,
  output logic                            out_low_level_crossed,
  output logic                            out_high_level_crossed,
  output logic                            out_settled_flag,
  output logic [TIME_BITS-1:0]            out_settle_time,
  output logic signed [OVS_W-1:0]         out_overshoot_centipercent,
  output logic [POSITION_BITS-1:0]        out_final_error,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data
);

  sra_cmd_t cmd;
  sra_sts_t sts;

  assign cfg_ready = 1'b1;

  sra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sra_datapath #(
    .POSITION_BITS (POSITION_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_datapath (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .cmd                        (cmd),
    .sts                        (sts),
    .cfg_write                  (cfg_valid && cfg_ready),
    .cfg_index                  (cfg_index),
    .cfg_data                   (cfg_data),
    .in_desired_position        (in_desired_position),
    .in_actual_position         (in_actual_position),
    .in_sample_time             (in_sample_time),
    .in_last_sample             (in_last_sample),
    .out_status                 (out_status),
    .out_rise_time              (out_rise_time),
    .out_low_level_crossed      (out_low_level_crossed),
    .out_high_level_crossed     (out_high_level_crossed),
    .out_settled_flag           (out_settled_flag),
    .out_settle_time            (out_settle_time),
    .out_overshoot_centipercent (out_overshoot_centipercent),
    .out_final_error            (out_final_error)
  );

endmodule

FILE: src/sra_ctrl.sv
// Controller of the step response analyser: sequences sample capture, step
// detection, level multiplies, tracking and the overshoot division. Uses sra_pkg.
`timescale 1ns / 1ps

module sra_ctrl import sra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  sra_sts_t sts,
  output sra_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DETECT,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_BAND,
    S_MUL_DONE,
    S_TRACK,
    S_OVS_DIFF,
    S_OVS_MUL,
    S_DIV_INIT,
    S_DIV,
    S_FINISH
  } state_t;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  state_t                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          state_nxt       = S_DETECT;
        end
      end
      S_DETECT: begin
        cmd.detect = 1'b1;
        state_nxt  = sts.step_hit ? S_MUL_LO : S_TRACK;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_MUL_BAND;
      end
      S_MUL_BAND: begin
        cmd.mul_band = 1'b1;
        state_nxt    = S_MUL_DONE;
      end
      S_MUL_DONE: begin
        cmd.band_done = 1'b1;
        state_nxt     = S_TRACK;
      end
      S_TRACK: begin
        cmd.track = 1'b1;
        state_nxt = sts.last ? S_OVS_DIFF : S_IDLE;
      end
      S_OVS_DIFF: begin
        cmd.ovs_diff = 1'b1;
        state_nxt    = S_OVS_MUL;
      end
      S_OVS_MUL: begin
        cmd.ovs_mul = 1'b1;
        state_nxt   = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // The result register is loaded only once the previous result has gone.
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/sra_datapath.sv
// Datapath of the step response analyser: configuration registers, analysis
// state, the shared multiplier, the restoring divider and the result register.
// Uses sra_pkg; driven by sra_ctrl.
`timescale 1ns / 1ps

module sra_datapath import sra_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sra_cmd_t                        cmd,
  output sra_sts_t                        sts,
  input  logic                            cfg_write,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data,
  input  logic signed [POSITION_BITS-1:0] in_desired_position,
  input  logic signed [POSITION_BITS-1:0] in_actual_position,
  input  logic [TIME_BITS-1:0]            in_sample_time,
  input  logic                            in_last_sample,
  output logic [STATUS_W-1:0]             out_status,
  output logic signed [TIME_BITS:0]       out_rise_time,
  output logic                            out_low_level_crossed,
  output logic                            out_high_level_crossed,
  output logic                            out_settled_flag,
  output logic [TIME_BITS-1:0]            out_settle_time,
  output logic signed [OVS_W-1:0]         out_overshoot_centipercent,
  output logic [POSITION_BITS-1:0]        out_final_error
);

  localparam int MAG_W     = POSITION_BITS + 1;
  localparam int LVL_W     = POSITION_BITS + 2;
  localparam int PROD_W    = MAG_W + FRAC_W;
  localparam int THR_CMP_W = (MAG_W > THRESH_W) ? MAG_W : THRESH_W;
  localparam int RISE_W    = TIME_BITS + 1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration registers.
  logic [THRESH_W-1:0] thr_r;
  logic [FRAC_W-1:0]   low_frac_r, high_frac_r, band_frac_r;
  logic [COUNT_W-1:0]  min_samples_r;

  // Captured sample.
  logic signed [POSITION_BITS-1:0] des_r, act_r;
  logic [TIME_BITS-1:0]            time_r;
  logic                            last_r;

  // Analysis state.
  logic [COUNT_W-1:0]              count_r;
  logic signed [POSITION_BITS-1:0] prev_r;
  logic                            step_seen_r, up_r;
  logic signed [POSITION_BITS-1:0] start_r, target_r, peak_r;
  logic [TIME_BITS-1:0]            start_time_r;
  logic [MAG_W-1:0]                mag_r, band_w_r;
  logic signed [LVL_W-1:0]         lower_r, upper_r;
  logic                            lo_seen_r, up_seen_r, band_r;
  logic [TIME_BITS-1:0]            lo_t_r, up_t_r, band_t_r;

  // Multiplier and divider.
  logic [PROD_W-1:0] prod_r;
  logic [MAG_W-1:0]  ovs_ad_r;
  logic              ovs_neg_r;
  logic [MAG_W-1:0]  rem_r;
  logic [FRAC_W-1:0] num_lo_r;
  logic [OVS_W-1:0]  quot_r;
  logic              div_sat_r;

  // Result register.
  logic [STATUS_W-1:0]      res_status_r;
  logic [RISE_W-1:0]        res_rise_r;
  logic                     res_lo_r, res_hi_r, res_settled_r;
  logic [TIME_BITS-1:0]     res_settle_r;
  logic [OVS_W-1:0]         res_ovs_r;
  logic [POSITION_BITS-1:0] res_err_r;

  // Step detection.
  logic [MAG_W-1:0] jump, jump_mag;
  logic             step_hit;

  assign jump     = {des_r[POSITION_BITS-1], des_r} - {prev_r[POSITION_BITS-1], prev_r};
  assign jump_mag = jump[MAG_W-1] ? (~jump + 1'b1) : jump;
  assign step_hit = !step_seen_r && (count_r != '0) &&
                    (THR_CMP_W'(jump_mag) > THR_CMP_W'(thr_r));

  assign sts.step_hit = step_hit;
  assign sts.last     = last_r;

  // Multiplier operand selection.
  logic [MAG_W-1:0]  mul_a;
  logic [FRAC_W-1:0] mul_b;
  logic              mul_en;

  always_comb begin
    mul_a = cmd.ovs_mul ? ovs_ad_r : mag_r;
    priority if (cmd.mul_hi) begin
      mul_b = high_frac_r;
    end else if (cmd.mul_band) begin
      mul_b = band_frac_r;
    end else if (cmd.ovs_mul) begin
      mul_b = OVS_SCALE;
    end else begin
      mul_b = low_frac_r;
    end
  end

  assign mul_en = cmd.mul_lo || cmd.mul_hi || cmd.mul_band || cmd.ovs_mul;

  // Rise levels from the previous product: start plus or minus the offset.
  logic [MAG_W-1:0] off;
  logic [LVL_W-1:0] lvl_start, lvl_off, level_val;

  assign off       = prod_r[PROD_W-1:FRAC_W];
  assign lvl_start = {{2{start_r[POSITION_BITS-1]}}, start_r};
  assign lvl_off   = {1'b0, off};
  assign level_val = up_r ? (lvl_start + lvl_off) : (lvl_start - lvl_off);

  // Tracking.
  logic signed [LVL_W-1:0] act_ext;
  logic [MAG_W-1:0]        dev, dev_abs;
  logic [TIME_BITS-1:0]    rel_t;
  logic                    track_on, low_hit, high_hit, peak_move;

  assign act_ext   = $signed({{2{act_r[POSITION_BITS-1]}}, act_r});
  assign dev       = {act_r[POSITION_BITS-1], act_r} - {target_r[POSITION_BITS-1], target_r};
  assign dev_abs   = dev[MAG_W-1] ? (~dev + 1'b1) : dev;
  assign rel_t     = time_r - start_time_r;
  assign track_on  = step_seen_r && !band_r;
  assign low_hit   = up_r ? (act_ext >= lower_r) : (act_ext <= lower_r);
  assign high_hit  = up_r ? (act_ext >= upper_r) : (act_ext <= upper_r);
  assign peak_move = up_r ? (act_r > peak_r) : (act_r < peak_r);

  // Overshoot: signed distance of the peak beyond the target, in step direction.
  logic [MAG_W-1:0] pk_ext, tg_ext, ovs_d;

  assign pk_ext = {peak_r[POSITION_BITS-1], peak_r};
  assign tg_ext = {target_r[POSITION_BITS-1], target_r};
  assign ovs_d  = up_r ? (pk_ext - tg_ext) : (tg_ext - pk_ext);

  // One restoring division step.
  logic [MAG_W:0] trial;
  logic           trial_ge;

  assign trial    = {rem_r, num_lo_r[FRAC_W-1]};
  assign trial_ge = (trial >= {1'b0, mag_r});

  // Result assembly.
  logic [STATUS_W-1:0]  status_val;
  logic [TIME_BITS-1:0] up_t_sel, lo_t_sel;
  logic [RISE_W-1:0]    rise_val;
  logic [OVS_W-1:0]     ovs_val;

  always_comb begin
    priority if (count_r < min_samples_r) begin
      status_val = STATUS_TOO_FEW;
    end else if (!step_seen_r) begin
      status_val = STATUS_NO_STEP;
    end else begin
      status_val = STATUS_OK;
    end
  end

  assign up_t_sel = up_seen_r ? up_t_r : '0;
  assign lo_t_sel = lo_seen_r ? lo_t_r : '0;
  assign rise_val = {1'b0, up_t_sel} - {1'b0, lo_t_sel};

  always_comb begin
    priority if (mag_r == '0) begin
      ovs_val = '0;
    end else if (ovs_neg_r) begin
      // A peak short of the target is never more than the whole step.
      ovs_val = -{1'b0, quot_r[OVS_W-2:0]};
    end else if (div_sat_r || quot_r[OVS_W-1]) begin
      ovs_val = OVS_MAX;
    end else begin
      ovs_val = quot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r         <= RST_STEP_THRESHOLD;
      low_frac_r    <= RST_RISE_LOW;
      high_frac_r   <= RST_RISE_HIGH;
      band_frac_r   <= RST_SETTLE_BAND;
      min_samples_r <= RST_MIN_SAMPLES;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STEP_THRESHOLD:       thr_r         <= cfg_data[THRESH_W-1:0];
        CFG_RISE_LOW_FRACTION:    low_frac_r    <= cfg_data[FRAC_W-1:0];
        CFG_RISE_HIGH_FRACTION:   high_frac_r   <= cfg_data[FRAC_W-1:0];
        CFG_SETTLE_BAND_FRACTION: band_frac_r   <= cfg_data[FRAC_W-1:0];
        CFG_MIN_SAMPLES:          min_samples_r <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state of the analysis, cleared after each record.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      count_r     <= '0;
      prev_r      <= '0;
      step_seen_r <= 1'b0;
      lo_seen_r   <= 1'b0;
      up_seen_r   <= 1'b0;
      band_r      <= 1'b0;
    end else begin
      if (cmd.detect && step_hit) begin
        step_seen_r <= 1'b1;
      end
      if (cmd.track) begin
        if (track_on) begin
          if (!lo_seen_r && low_hit) begin
            lo_seen_r <= 1'b1;
          end
          if (!up_seen_r && high_hit) begin
            up_seen_r <= 1'b1;
          end
          if (dev_abs < band_w_r) begin
            band_r <= 1'b1;
          end
        end
        prev_r <= des_r;
        if (count_r != COUNT_MAX) begin
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      des_r  <= in_desired_position;
      act_r  <= in_actual_position;
      time_r <= in_sample_time;
      last_r <= in_last_sample;
    end
    if (cmd.detect && step_hit) begin
      start_r      <= prev_r;
      target_r     <= des_r;
      start_time_r <= time_r;
      mag_r        <= jump_mag;
      up_r         <= !jump[MAG_W-1];
      peak_r       <= prev_r;
    end
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.mul_hi) begin
      lower_r <= $signed(level_val);
    end
    if (cmd.mul_band) begin
      upper_r <= $signed(level_val);
    end
    if (cmd.band_done) begin
      band_w_r <= off;
    end
    if (cmd.track && track_on) begin
      if (!lo_seen_r && low_hit) begin
        lo_t_r <= rel_t;
      end
      if (!up_seen_r && high_hit) begin
        up_t_r <= rel_t;
      end
      if (peak_move) begin
        peak_r <= act_r;
      end
      if (!band_r && (dev_abs < band_w_r)) begin
        band_t_r <= rel_t;
      end
    end
    if (cmd.ovs_diff) begin
      ovs_neg_r <= ovs_d[MAG_W-1];
      ovs_ad_r  <= ovs_d[MAG_W-1] ? (~ovs_d + 1'b1) : ovs_d;
    end
    if (cmd.div_init) begin
      // A high part at or above the divisor means a quotient beyond 16 bits.
      rem_r     <= prod_r[PROD_W-1:FRAC_W];
      div_sat_r <= (prod_r[PROD_W-1:FRAC_W] >= mag_r);
      num_lo_r  <= prod_r[FRAC_W-1:0];
      quot_r    <= '0;
    end
    if (cmd.div_step) begin
      rem_r    <= trial_ge ? MAG_W'(trial - {1'b0, mag_r}) : trial[MAG_W-1:0];
      quot_r   <= {quot_r[OVS_W-2:0], trial_ge};
      num_lo_r <= {num_lo_r[FRAC_W-2:0], 1'b0};
    end
    if (cmd.finish) begin
      res_status_r <= status_val;
      if (status_val == STATUS_OK) begin
        res_rise_r    <= rise_val;
        res_lo_r      <= lo_seen_r;
        res_hi_r      <= up_seen_r;
        res_settled_r <= band_r;
        res_settle_r  <= band_r ? band_t_r : '0;
        res_ovs_r     <= ovs_val;
        res_err_r     <= dev_abs[POSITION_BITS-1:0];
      end else begin
        res_rise_r    <= '0;
        res_lo_r      <= 1'b0;
        res_hi_r      <= 1'b0;
        res_settled_r <= 1'b0;
        res_settle_r  <= '0;
        res_ovs_r     <= '0;
        res_err_r     <= '0;
      end
    end
  end

  // The final error uses the last actual position, which is still in act_r.
  assign out_status                 = res_status_r;
  assign out_rise_time              = $signed(res_rise_r);
  assign out_low_level_crossed      = res_lo_r;
  assign out_high_level_crossed     = res_hi_r;
  assign out_settled_flag           = res_settled_r;
  assign out_settle_time            = res_settle_r;
  assign out_overshoot_centipercent = $signed(res_ovs_r);
  assign out_final_error            = res_err_r;

endmodule

FILE: dv/tb_step_response_analyzer.sv
// Self-checking testbench for step_response_analyzer: random and directed sample records,
// checked against a behavioural predictor of the analysis. Depends on sra_pkg and the RTL.
`timescale 1ns / 1ps

module tb_step_response_analyzer;
  import sra_pkg::*;

  localparam int PB = POSITION_BITS_DEF;
  localparam int TB = TIME_BITS_DEF;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint MAG_MAX = 64'sd4294967295;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 200;
  localparam int RANDOM_PHASES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef struct packed {
    logic signed [PB-1:0] des;
    logic signed [PB-1:0] act;
    logic [TB-1:0]        stamp;
    logic                 is_last;
  } sample_t;

  typedef struct packed {
    status_t              status;
    logic signed [TB:0]   rise;
    logic                 lo_hit;
    logic                 hi_hit;
    logic                 settled;
    logic [TB-1:0]        settle_t;
    logic signed [OVS_W-1:0] ovs;
    logic [PB-1:0]        err;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [PB-1:0] in_desired_position = '0;
  logic signed [PB-1:0] in_actual_position = '0;
  logic [TB-1:0] in_sample_time = '0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic signed [TB:0] out_rise_time;
  logic out_low_level_crossed;
  logic out_high_level_crossed;
  logic out_settled_flag;
  logic [TB-1:0] out_settle_time;
  logic signed [OVS_W-1:0] out_overshoot_centipercent;
  logic [PB-1:0] out_final_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sample_t pending_samples[$];
  report_t expected_reports[$];
  sample_t drive_item;
  report_t seen_report;
  int errors = 0;
  int queued_total = 0;
  int send_max = 12;
  int recv_max = 12;
  int send_gap = 0;
  int stall_left = 0;
  int cycle_count = 0;

  // Predictor copy of the registers.
  logic [THRESH_W-1:0] thr_reg;
  logic [FRAC_W-1:0]   low_frac;
  logic [FRAC_W-1:0]   high_frac;
  logic [FRAC_W-1:0]   band_frac;
  logic [COUNT_W-1:0]  min_reg;

  // Predictor copy of the analysis state.
  logic [31:0] seen_count;
  longint prev_des;
  bit stepped;
  longint start_pos, target_pos;
  logic [TB-1:0] start_t;
  longint lo_lvl, hi_lvl, band;
  bit lo_hit, hi_hit, settled;
  logic [TB-1:0] lo_t, hi_t, settle_t;
  longint peak, last_act;

  step_response_analyzer dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_desired_position        (in_desired_position),
    .in_actual_position         (in_actual_position),
    .in_sample_time             (in_sample_time),
    .in_last_sample             (in_last_sample),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_status                 (out_status),
    .out_rise_time              (out_rise_time),
    .out_low_level_crossed      (out_low_level_crossed),
    .out_high_level_crossed     (out_high_level_crossed),
    .out_settled_flag           (out_settled_flag),
    .out_settle_time            (out_settle_time),
    .out_overshoot_centipercent (out_overshoot_centipercent),
    .out_final_error            (out_final_error),
    .cfg_valid                  (cfg_valid),
    .cfg_ready                  (cfg_ready),
    .cfg_index                  (cfg_index),
    .cfg_data                   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint abs_gap(input longint a, input longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Exact floor(mag * f / 65536) without overflowing the product.
  function automatic longint scaled(input longint mag, input logic [FRAC_W-1:0] f);
    longint fl;
    fl = longint'(f);
    return (mag >> 16) * fl + (((mag & 64'hFFFF) * fl) >> 16);
  endfunction

  function automatic int draw_wait(input int top);
    if (top == 0 || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, top);
  endfunction

  task automatic clear_analysis();
    seen_count = '0; prev_des = 0; stepped = 0;
    start_pos = 0; target_pos = 0; start_t = '0;
    lo_lvl = 0; hi_lvl = 0; band = 0;
    lo_hit = 0; lo_t = '0; hi_hit = 0; hi_t = '0;
    peak = 0; settled = 0; settle_t = '0; last_act = 0;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_STEP_THRESHOLD:       thr_reg = val[THRESH_W-1:0];
      CFG_RISE_LOW_FRACTION:    low_frac = val[FRAC_W-1:0];
      CFG_RISE_HIGH_FRACTION:   high_frac = val[FRAC_W-1:0];
      CFG_SETTLE_BAND_FRACTION: band_frac = val[FRAC_W-1:0];
      CFG_MIN_SAMPLES:          min_reg = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Updates the analysis with one accepted sample and queues the report that
  // a final sample produces.
  task automatic analyse_sample(input sample_t s);
    longint des, act, mag, d, ad, q, r, v, ov, rise, fe;
    logic [TB-1:0] rel;
    bit up;
    report_t rep;
    des = longint'(s.des);
    act = longint'(s.act);
    if (!stepped && seen_count != 0 && abs_gap(des, prev_des) > longint'(thr_reg)) begin
      mag = abs_gap(des, prev_des);
      up = des > prev_des;
      stepped = 1;
      start_pos = prev_des;
      target_pos = des;
      start_t = s.stamp;
      lo_lvl = up ? prev_des + scaled(mag, low_frac) : prev_des - scaled(mag, low_frac);
      hi_lvl = up ? prev_des + scaled(mag, high_frac) : prev_des - scaled(mag, high_frac);
      band = scaled(mag, band_frac);
      peak = prev_des;
    end
    if (stepped && !settled) begin
      up = target_pos > start_pos;
      rel = s.stamp - start_t;
      if (!lo_hit && (up ? act >= lo_lvl : act <= lo_lvl)) begin
        lo_hit = 1;
        lo_t = rel;
      end
      if (!hi_hit && (up ? act >= hi_lvl : act <= hi_lvl)) begin
        hi_hit = 1;
        hi_t = rel;
      end
      if (up ? act > peak : act < peak) peak = act;
      if (abs_gap(act, target_pos) < band) begin
        settled = 1;
        settle_t = rel;
      end
    end
    prev_des = des;
    last_act = act;
    if (seen_count != 32'hFFFF_FFFF) seen_count = seen_count + 1;
    if (!s.is_last) return;

    rep = '0;
    if (seen_count < 32'(min_reg)) begin
      rep.status = STATUS_TOO_FEW;
    end else if (!stepped) begin
      rep.status = STATUS_NO_STEP;
    end else begin
      rep.status = STATUS_OK;
      mag = abs_gap(target_pos, start_pos);
      up = target_pos > start_pos;
      d = up ? peak - target_pos : target_pos - peak;
      ov = 0;
      if (mag != 0) begin
        ad = (d < 0) ? -d : d;
        q = ad / mag;
        r = ad % mag;
        v = (q >= 4) ? 40000 : q * 10000 + (r * 10000) / mag;
        ov = (d < 0) ? -v : ((v > 32767) ? 32767 : v);
      end
      rise = (hi_hit ? longint'(hi_t) : 0) - (lo_hit ? longint'(lo_t) : 0);
      fe = abs_gap(last_act, target_pos);
      rep.rise = rise[TB:0];
      rep.lo_hit = lo_hit;
      rep.hi_hit = hi_hit;
      rep.settled = settled;
      rep.settle_t = settled ? settle_t : '0;
      rep.ovs = ov[OVS_W-1:0];
      rep.err = fe[PB-1:0];
    end
    expected_reports = {expected_reports, rep};
    clear_analysis();
  endtask

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic check_report(input report_t got);
    report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: result with none expected, expected nothing, actual status %0d",
               $time, got.status);
      errors++;
      return;
    end
    want = expected_reports.pop_front();
    compare_field("status", 64'(want.status), 64'(got.status));
    compare_field("rise_time", 64'(want.rise), 64'(got.rise));
    compare_field("low_level_crossed", 64'(want.lo_hit), 64'(got.lo_hit));
    compare_field("high_level_crossed", 64'(want.hi_hit), 64'(got.hi_hit));
    compare_field("settled_flag", 64'(want.settled), 64'(got.settled));
    compare_field("settle_time", 64'(want.settle_t), 64'(got.settle_t));
    compare_field("overshoot_centipercent", 64'(want.ovs), 64'(got.ovs));
    compare_field("final_error", 64'(want.err), 64'(got.err));
  endtask

  // Sample driver: one transaction per queued sample, with a random gap after each.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) analyse_sample(drive_item);
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        drive_item = pending_samples.pop_front();
        in_desired_position <= drive_item.des;
        in_actual_position <= drive_item.act;
        in_sample_time <= drive_item.stamp;
        in_last_sample <= drive_item.is_last;
        in_valid <= 1'b1;
        send_gap <= draw_wait(send_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor. After each transaction the receiver stalls for a drawn
  // number of cycles, counted while a result is on offer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_report.status = status_t'(out_status);
        seen_report.rise = out_rise_time;
        seen_report.lo_hit = out_low_level_crossed;
        seen_report.hi_hit = out_high_level_crossed;
        seen_report.settled = out_settled_flag;
        seen_report.settle_t = out_settle_time;
        seen_report.ovs = out_overshoot_centipercent;
        seen_report.err = out_final_error;
        check_report(seen_report);
        stall_left = draw_wait(recv_max);
      end else if (out_valid && stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_step_response_analyzer: errors");
      $finish;
    end
  end

  task automatic queue_sample(input longint des, input longint act,
                              input logic [TB-1:0] stamp, input bit is_last);
    sample_t s;
    s.des = des[PB-1:0];
    s.act = act[PB-1:0];
    s.stamp = stamp;
    s.is_last = is_last;
    pending_samples = {pending_samples, s};
    queued_total++;
  endtask

  // One record: a settled start, a step sized from the current threshold and
  // an actual position that rises, peaks and decays towards the target.
  // Untidy records carry fully random fields and stray final-sample marks.
  task automatic queue_record(input bit tidy);
    int n, k, i, rate, peak_p, p, since;
    longint s, m, dir, lo_b, hi_b, span, des, act;
    logic [TB-1:0] t;
    bit has_step, stuck, peaked;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
    if (!tidy) begin
      for (i = 0; i < n; i++)
        queue_sample(longint'($urandom), longint'($urandom), $urandom,
                     ($urandom_range(0, 5) == 0) || (i == n - 1));
      return;
    end
    has_step = (n >= 2) && ($urandom_range(0, 9) != 0);
    stuck = ($urandom_range(0, 15) == 0);
    k = (n >= 2) ? $urandom_range(1, n - 1) : 0;
    m = longint'(thr_reg) + 1 + (($urandom_range(0, 3) == 0) ?
        longint'($urandom_range(0, 1 << 20)) : longint'($urandom_range(0, 4000)));
    if (m > MAG_MAX) m = MAG_MAX;
    dir = $urandom_range(0, 1) ? 1 : -1;
    lo_b = (dir > 0) ? POS_MIN : POS_MIN + m;
    hi_b = (dir > 0) ? POS_MAX - m : POS_MAX;
    span = hi_b - lo_b;
    if ($urandom_range(0, 3) == 0) begin
      s = lo_b + longint'({$urandom, $urandom} >> 1) % (span + 1);
    end else begin
      s = longint'($urandom_range(0, 200000)) - 100000;
      if (s < lo_b) s = lo_b;
      if (s > hi_b) s = hi_b;
    end
    rate = $urandom_range(40, 700);
    peak_p = ($urandom_range(0, 3) == 0) ? $urandom_range(500, 1100) : $urandom_range(1024, 1500);
    peaked = 0;
    since = 0;
    t = $urandom;
    for (i = 0; i < n; i++) begin
      if (!has_step || i < k) begin
        des = s;
        p = 0;
      end else begin
        des = s + dir * m;
        // A later jump of the command must be ignored.
        if (i > k && $urandom_range(0, 19) == 0) des = longint'($urandom);
        if (stuck) begin
          p = 0;
        end else if (!peaked) begin
          p = (i - k) * rate;
          if (p >= peak_p) begin
            p = peak_p;
            peaked = 1;
          end
        end else begin
          since++;
          p = 1024 + (peak_p - 1024) / (since + 1);
        end
      end
      act = s + dir * ((m * longint'(p)) / 1024) + longint'($urandom_range(0, 8)) - 4;
      if (act < POS_MIN) act = POS_MIN;
      if (act > POS_MAX) act = POS_MAX;
      queue_sample(des, act, t, i == n - 1);
      t = t + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1000));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] thr, input logic [31:0] lo, input logic [31:0] hi,
                           input logic [31:0] bw, input logic [31:0] mn);
    write_reg(CFG_STEP_THRESHOLD, thr);
    write_reg(CFG_RISE_LOW_FRACTION, lo);
    write_reg(CFG_RISE_HIGH_FRACTION, hi);
    write_reg(CFG_SETTLE_BAND_FRACTION, bw);
    write_reg(CFG_MIN_SAMPLES, mn);
  endtask

  // Holds the sender back until every expected report is in and the block
  // has had time to finish any sample that produces none.
  task automatic wait_idle();
    @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int ph, start;
    logic [31:0] thr;
    thr_reg = RST_STEP_THRESHOLD;
    low_frac = RST_RISE_LOW;
    high_frac = RST_RISE_HIGH;
    band_frac = RST_SETTLE_BAND;
    min_reg = RST_MIN_SAMPLES;
    clear_analysis();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed records.
    write_all(100, 6554, 58982, 1311, 3);
    send_max = 3;
    recv_max = 3;
    // A lone first sample is never a step; too few samples wins over no step.
    queue_sample(POS_MAX, POS_MIN, 32'hFFFF_FFFF, 1);
    // Jumps exactly equal to the threshold do not count.
    queue_sample(0, 5, 10, 0);
    queue_sample(100, 0, 20, 0);
    queue_sample(200, -5, 30, 1);
    // Full-scale rising step with the timestamp wrapping; a later jump is ignored.
    queue_sample(POS_MIN, POS_MIN, 32'hFFFF_FFF0, 0);
    queue_sample(POS_MAX, POS_MIN, 32'hFFFF_FFF8, 0);
    queue_sample(POS_MAX, POS_MAX, 8, 0);
    queue_sample(POS_MIN, 0, 20, 1);
    // Small step with a huge peak: overshoot saturates.
    queue_sample(0, 0, 0, 0);
    queue_sample(200, 0, 1, 0);
    queue_sample(200, POS_MAX, 2, 0);
    queue_sample(200, 200, 3, 1);
    // Falling step, lower level hit exactly, overshoot below the target.
    queue_sample(0, 0, 100, 0);
    queue_sample(-1000, 0, 101, 0);
    queue_sample(-1000, -100, 105, 0);
    queue_sample(-1000, -1200, 110, 0);
    queue_sample(-1000, -990, 120, 1);
    // Falling step reaching only the lower level: negative rise time.
    queue_sample(5, 5, 0, 0);
    queue_sample(-500, 5, 7, 0);
    queue_sample(-500, -60, 9, 0);
    queue_sample(-500, 5, 12, 1);
    // Actual never moves: overshoot of minus one whole step.
    queue_sample(5, 5, 0, 0);
    queue_sample(-500, 5, 7, 0);
    queue_sample(-500, 5, 9, 1);
    wait_idle();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_all(32'(RST_STEP_THRESHOLD), 32'(RST_RISE_LOW), 32'(RST_RISE_HIGH),
                    32'(RST_SETTLE_BAND), 32'(RST_MIN_SAMPLES));
          send_max = 12;
          recv_max = 12;
        end
        1: begin
          write_all(0, 0, 65535, 65535, 0);
          send_max = 0;
          recv_max = 0;
        end
        2: begin
          write_all(32'hFFFF_FFFF, 65535, 0, 0, 65535);
          send_max = 12;
          recv_max = 0;
        end
        default: begin
          case ($urandom_range(0, 2))
            0: thr = $urandom_range(0, 1000);
            1: thr = $urandom_range(0, 1 << 20);
            default: thr = $urandom;
          endcase
          write_all(thr, $urandom, $urandom, $urandom,
                    ($urandom & 32'hFFFF_0000) | $urandom_range(0, 15));
          if (ph == 3) write_reg(CFG_SPARE_IDX, $urandom);
          send_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
          recv_max = ($urandom_range(0, 2) == 0) ? 4 : 12;
        end
      endcase
      start = queued_total;
      while (queued_total - start < PHASE_ITEMS)
        queue_record($urandom_range(0, 6) != 0);
      wait_idle();
    end

    if (errors == 0)
      $display("tb_step_response_analyzer: clean");
    else
      $display("tb_step_response_analyzer: errors");
    $finish;
  end

endmodule

FILE: filelist.f
src/sra_pkg.sv
src/sra_ctrl.sv
src/sra_datapath.sv
src/step_response_analyzer.sv
dv/tb_step_response_analyzer.sv
